FILE: rtl/core/srsp_pkg.sv
`default_nettype none
package srsp_pkg;

  localparam int unsigned SilenceLen = 36;
  localparam int unsigned SilIdxW = 6;

  localparam logic [7:0] FadeTicksRst = 8'd40;
  localparam logic [7:0] WaitCodeRst = 8'd0;
  localparam logic [7:0] WriteCodeRst = 8'd1;
  localparam logic [7:0] EndCodeRst = 8'd2;

  localparam logic [7:0] RegMaster = 8'h80;
  localparam logic [7:0] RegWave0 = 8'h90;
  localparam logic [7:0] RegWave1 = 8'h91;
  localparam logic [7:0] Wave0Match = 8'h04;
  localparam logic [7:0] Wave0Subst = 8'h01;
  localparam logic [7:0] Wave1Match = 8'h92;
  localparam logic [7:0] Wave1Subst = 8'h31;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_BYTE   = 3'd1,
    CMD_PLAY   = 3'd2,
    CMD_FADE   = 3'd3,
    CMD_HEAD   = 3'd4,
    CMD_STOP   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_FADE_TICKS = 2'd0,
    CFG_WAIT_CODE  = 2'd1,
    CFG_WRITE_CODE = 2'd2,
    CFG_END_CODE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_PLAY = 2'd1,
    MODE_NEXT = 2'd2,
    MODE_FADE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CMD  = 3'd1,
    PH_ADDR = 3'd2,
    PH_DATA = 3'd3,
    PH_OFF0 = 3'd4,
    PH_OFF1 = 3'd5,
    PH_OFF2 = 3'd6,
    PH_OFF3 = 3'd7
  } phase_t;

  typedef struct packed {
    logic        wr;
    logic [7:0]  wr_off;
    logic [7:0]  wr_val;
    logic        sil;
    logic        fetch;
    logic [31:0] fetch_addr;
    logic        playing;
    logic        headset;
    logic        bad;
  } desc_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] val;
  } fade_step_t;

  function automatic fade_step_t fade_level(input logic [7:0] cnt);
    fade_step_t r;
    r.hit = 1'b1;
    unique case (cnt)
      8'd35:   r.val = 8'h66;
      8'd30:   r.val = 8'h55;
      8'd25:   r.val = 8'h44;
      8'd20:   r.val = 8'h33;
      8'd15:   r.val = 8'h22;
      8'd10:   r.val = 8'h11;
      8'd5:    r.val = 8'h00;
      default: begin
        r.hit = 1'b0;
        r.val = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic logic [15:0] silence_entry(input logic [SilIdxW-1:0] idx);
    logic [15:0] e;
    unique case (idx)
      6'd0:    e = 16'h6000;
      6'd1:    e = 16'h6200;
      6'd2:    e = 16'h6308;
      6'd3:    e = 16'h6400;
      6'd4:    e = 16'h6580;
      6'd5:    e = 16'h6800;
      6'd6:    e = 16'h6908;
      6'd7:    e = 16'h6c00;
      6'd8:    e = 16'h6d80;
      6'd9:    e = 16'h9000;
      6'd10:   e = 16'h9100;
      6'd11:   e = 16'h9200;
      6'd12:   e = 16'h9300;
      6'd13:   e = 16'h9400;
      6'd14:   e = 16'h9500;
      6'd15:   e = 16'h9600;
      6'd16:   e = 16'h9700;
      6'd17:   e = 16'h9800;
      6'd18:   e = 16'h9900;
      6'd19:   e = 16'h9a00;
      6'd20:   e = 16'h9b00;
      6'd21:   e = 16'h9c00;
      6'd22:   e = 16'h9d00;
      6'd23:   e = 16'h9e00;
      6'd24:   e = 16'h9f00;
      6'd25:   e = 16'h7000;
      6'd26:   e = 16'h7200;
      6'd27:   e = 16'h7300;
      6'd28:   e = 16'h7400;
      6'd29:   e = 16'h7500;
      6'd30:   e = 16'h7800;
      6'd31:   e = 16'h7908;
      6'd32:   e = 16'h7c00;
      6'd33:   e = 16'h7d80;
      6'd34:   e = 16'h8077;
      6'd35:   e = 16'h81ff;
      default: e = 16'h0000;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sound_register_stream_player.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_ready    cmd, stream_byte, song_base, loop_enable
// out_     output     out_valid/out_ready  write, register offset/value, fetch, status
// cfg_     input      cfg_we               cfg_index, cfg_data
//
// One input transaction is decoded in the cycle it is accepted and lands in a
// one-entry job register; an emitter register then presents its results.
// A transaction yields 1 or 36 results, one per cycle on out_ while out_ready
// is high; the 36 come from the silence table walk.
// Input is taken every cycle while the emitter keeps pace; with out_ready low
// one more transaction is absorbed, then in_ready drops.
// Reset is synchronous on rst_n and leaves the player stopped.
`default_nettype none
module sound_register_stream_player (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [7:0]  in_stream_byte,
  input  wire logic [31:0] in_song_base,
  input  wire logic        in_loop_enable,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_write_valid,
  output logic [7:0]       out_reg_offset,
  output logic [7:0]       out_reg_value,
  output logic             out_fetch_valid,
  output logic [31:0]      out_fetch_address,
  output logic             out_playing,
  output logic             out_headset_on,
  output logic             out_bad_command,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic            in_fire;
  srsp_pkg::desc_t desc;

  assign in_fire = in_valid && in_ready;

  srsp_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_cmd         (in_cmd),
    .in_stream_byte (in_stream_byte),
    .in_song_base   (in_song_base),
    .in_loop_enable (in_loop_enable),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .desc           (desc)
  );

  srsp_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_fire           (in_fire),
    .in_desc           (desc),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_valid   (out_write_valid),
    .out_reg_offset    (out_reg_offset),
    .out_reg_value     (out_reg_value),
    .out_fetch_valid   (out_fetch_valid),
    .out_fetch_address (out_fetch_address),
    .out_playing       (out_playing),
    .out_headset_on    (out_headset_on),
    .out_bad_command   (out_bad_command),
    .out_last          (out_last)
  );

`ifndef ASSERT_OFF
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("multi-result transaction broke off");

  a_no_fetch_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_playing |-> !out_fetch_valid)
    else $error("fetch requested while stopped");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/srsp_ctrl.sv
`default_nettype none
module srsp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_fire,
  input  wire logic [2:0]          in_cmd,
  input  wire logic [7:0]          in_stream_byte,
  input  wire logic [31:0]         in_song_base,
  input  wire logic                in_loop_enable,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data,
  output srsp_pkg::desc_t          desc
);

  logic [7:0] fade_ticks_r, wait_code_r, write_code_r, end_code_r;

  srsp_pkg::mode_t  mode_r, mode_nxt;
  srsp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  fade_count_r, fade_count_nxt;
  logic [31:0] song_start_r, song_start_nxt;
  logic [31:0] cursor_r, cursor_nxt;
  logic        looping_r, looping_nxt;
  logic [31:0] queued_start_r, queued_start_nxt;
  logic        queued_looping_r, queued_looping_nxt;
  logic        headset_r, headset_nxt;
  logic [7:0]  held_address_r, held_address_nxt;
  logic [31:0] offset_accum_r, offset_accum_nxt;

  logic [7:0]  fc_dec;
  logic [31:0] cursor_inc;
  logic [31:0] accum_add;
  srsp_pkg::fade_step_t fstep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_ticks_r <= srsp_pkg::FadeTicksRst;
      wait_code_r  <= srsp_pkg::WaitCodeRst;
      write_code_r <= srsp_pkg::WriteCodeRst;
      end_code_r   <= srsp_pkg::EndCodeRst;
    end else if (cfg_we) begin
      unique case (srsp_pkg::cfg_idx_t'(cfg_index))
        srsp_pkg::CFG_FADE_TICKS: fade_ticks_r <= cfg_data;
        srsp_pkg::CFG_WAIT_CODE:  wait_code_r  <= cfg_data;
        srsp_pkg::CFG_WRITE_CODE: write_code_r <= cfg_data;
        srsp_pkg::CFG_END_CODE:   end_code_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= srsp_pkg::MODE_STOP;
      phase_r          <= srsp_pkg::PH_IDLE;
      fade_count_r     <= '0;
      song_start_r     <= '0;
      cursor_r         <= '0;
      looping_r        <= 1'b0;
      queued_start_r   <= '0;
      queued_looping_r <= 1'b0;
      headset_r        <= 1'b0;
      held_address_r   <= '0;
      offset_accum_r   <= '0;
    end else if (in_fire) begin
      mode_r           <= mode_nxt;
      phase_r          <= phase_nxt;
      fade_count_r     <= fade_count_nxt;
      song_start_r     <= song_start_nxt;
      cursor_r         <= cursor_nxt;
      looping_r        <= looping_nxt;
      queued_start_r   <= queued_start_nxt;
      queued_looping_r <= queued_looping_nxt;
      headset_r        <= headset_nxt;
      held_address_r   <= held_address_nxt;
      offset_accum_r   <= offset_accum_nxt;
    end
  end

  assign fc_dec     = fade_count_r - 8'd1;
  assign cursor_inc = cursor_r + 32'd1;
  assign fstep      = srsp_pkg::fade_level(fade_count_r);

  always_comb begin
    accum_add = offset_accum_r;
    case (phase_r[1:0])
      2'd0:    accum_add[7:0]   = offset_accum_r[7:0]   | in_stream_byte;
      2'd1:    accum_add[15:8]  = offset_accum_r[15:8]  | in_stream_byte;
      2'd2:    accum_add[23:16] = offset_accum_r[23:16] | in_stream_byte;
      default: accum_add[31:24] = offset_accum_r[31:24] | in_stream_byte;
    endcase
  end

  always_comb begin
    mode_nxt           = mode_r;
    phase_nxt          = phase_r;
    fade_count_nxt     = fade_count_r;
    song_start_nxt     = song_start_r;
    cursor_nxt         = cursor_r;
    looping_nxt        = looping_r;
    queued_start_nxt   = queued_start_r;
    queued_looping_nxt = queued_looping_r;
    headset_nxt        = headset_r;
    held_address_nxt   = held_address_r;
    offset_accum_nxt   = offset_accum_r;
    desc.wr     = 1'b0;
    desc.wr_off = '0;
    desc.wr_val = '0;
    desc.sil    = 1'b0;
    desc.bad    = 1'b0;

    unique case (in_cmd)
      srsp_pkg::CMD_TICK: begin
        if (mode_r != srsp_pkg::MODE_STOP) begin
          if (mode_r == srsp_pkg::MODE_NEXT || mode_r == srsp_pkg::MODE_FADE) begin
            if (fstep.hit) begin
              desc.wr     = 1'b1;
              desc.wr_off = srsp_pkg::RegMaster;
              desc.wr_val = fstep.val;
            end
            fade_count_nxt = fc_dec;
          end
          if ((mode_r == srsp_pkg::MODE_NEXT || mode_r == srsp_pkg::MODE_FADE) &&
              fc_dec == 8'd0) begin
            desc.sil  = 1'b1;
            phase_nxt = srsp_pkg::PH_IDLE;
            if (mode_r == srsp_pkg::MODE_NEXT) begin
              mode_nxt           = srsp_pkg::MODE_PLAY;
              fade_count_nxt     = '0;
              song_start_nxt     = queued_start_r;
              cursor_nxt         = queued_start_r;
              looping_nxt        = queued_looping_r;
              queued_start_nxt   = '0;
              queued_looping_nxt = 1'b0;
              headset_nxt        = 1'b0;
              held_address_nxt   = '0;
              offset_accum_nxt   = '0;
            end else begin
              mode_nxt = srsp_pkg::MODE_STOP;
            end
          end else if (phase_r == srsp_pkg::PH_IDLE) begin
            phase_nxt = srsp_pkg::PH_CMD;
          end
        end
      end
      srsp_pkg::CMD_BYTE: begin
        if (phase_r != srsp_pkg::PH_IDLE && mode_r != srsp_pkg::MODE_STOP) begin
          cursor_nxt = cursor_inc;
          unique case (phase_r) inside
            srsp_pkg::PH_CMD: begin
              if (in_stream_byte == wait_code_r) begin
                phase_nxt = srsp_pkg::PH_IDLE;
              end else if (in_stream_byte == write_code_r) begin
                phase_nxt = srsp_pkg::PH_ADDR;
              end else if (in_stream_byte == end_code_r) begin
                if (!looping_r) begin
                  mode_nxt  = srsp_pkg::MODE_STOP;
                  phase_nxt = srsp_pkg::PH_IDLE;
                  desc.sil  = 1'b1;
                end else begin
                  offset_accum_nxt = '0;
                  phase_nxt        = srsp_pkg::PH_OFF0;
                end
              end else begin
                mode_nxt  = srsp_pkg::MODE_STOP;
                phase_nxt = srsp_pkg::PH_IDLE;
                desc.bad  = 1'b1;
              end
            end
            srsp_pkg::PH_ADDR: begin
              held_address_nxt = in_stream_byte;
              phase_nxt        = srsp_pkg::PH_DATA;
            end
            srsp_pkg::PH_DATA: begin
              desc.wr     = 1'b1;
              desc.wr_off = held_address_r;
              desc.wr_val = in_stream_byte;
              if (headset_r && held_address_r == srsp_pkg::RegWave0 &&
                  in_stream_byte == srsp_pkg::Wave0Match) begin
                desc.wr_val = srsp_pkg::Wave0Subst;
              end else if (headset_r && held_address_r == srsp_pkg::RegWave1 &&
                           in_stream_byte == srsp_pkg::Wave1Match) begin
                desc.wr_val = srsp_pkg::Wave1Subst;
              end
              phase_nxt = srsp_pkg::PH_CMD;
            end
            srsp_pkg::PH_OFF0, srsp_pkg::PH_OFF1, srsp_pkg::PH_OFF2: begin
              offset_accum_nxt = accum_add;
              phase_nxt        = srsp_pkg::phase_t'(phase_r + 3'd1);
            end
            srsp_pkg::PH_OFF3: begin
              offset_accum_nxt = accum_add;
              cursor_nxt       = song_start_r + accum_add;
              phase_nxt        = srsp_pkg::PH_CMD;
            end
            default: ;
          endcase
        end
      end
      srsp_pkg::CMD_PLAY: begin
        if (mode_r == srsp_pkg::MODE_PLAY) begin
          queued_start_nxt   = in_song_base;
          queued_looping_nxt = in_loop_enable;
          fade_count_nxt     = fade_ticks_r;
          mode_nxt           = srsp_pkg::MODE_NEXT;
        end else if (mode_r == srsp_pkg::MODE_NEXT || mode_r == srsp_pkg::MODE_FADE) begin
          queued_start_nxt   = in_song_base;
          queued_looping_nxt = in_loop_enable;
          mode_nxt           = srsp_pkg::MODE_NEXT;
        end else begin
          desc.sil           = 1'b1;
          mode_nxt           = srsp_pkg::MODE_PLAY;
          phase_nxt          = srsp_pkg::PH_IDLE;
          fade_count_nxt     = '0;
          song_start_nxt     = in_song_base;
          cursor_nxt         = in_song_base;
          looping_nxt        = in_loop_enable;
          queued_start_nxt   = '0;
          queued_looping_nxt = 1'b0;
          headset_nxt        = 1'b0;
          held_address_nxt   = '0;
          offset_accum_nxt   = '0;
        end
      end
      srsp_pkg::CMD_FADE: begin
        fade_count_nxt = fade_ticks_r;
        mode_nxt       = srsp_pkg::MODE_FADE;
      end
      srsp_pkg::CMD_HEAD: begin
        headset_nxt = ~headset_r;
      end
      srsp_pkg::CMD_STOP: begin
        mode_nxt  = srsp_pkg::MODE_STOP;
        phase_nxt = srsp_pkg::PH_IDLE;
        desc.sil  = 1'b1;
      end
      default: ;
    endcase

    desc.fetch      = (phase_nxt != srsp_pkg::PH_IDLE);
    desc.fetch_addr = cursor_nxt;
    desc.playing    = (mode_nxt != srsp_pkg::MODE_STOP);
    desc.headset    = headset_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/core/srsp_emit.sv
`default_nettype none
module srsp_emit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire srsp_pkg::desc_t in_desc,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_write_valid,
  output logic [7:0]           out_reg_offset,
  output logic [7:0]           out_reg_value,
  output logic                 out_fetch_valid,
  output logic [31:0]          out_fetch_address,
  output logic                 out_playing,
  output logic                 out_headset_on,
  output logic                 out_bad_command,
  output logic                 out_last
);

  logic                           a_valid_r;
  srsp_pkg::desc_t                a_desc_r;
  logic                           b_valid_r;
  srsp_pkg::desc_t                b_desc_r;
  logic                           pre_r;
  logic [srsp_pkg::SilIdxW-1:0]   sil_idx_r;

  logic        b_last;
  logic        b_done;
  logic        a_move;
  logic [15:0] sil_word;

  assign sil_word = srsp_pkg::silence_entry(sil_idx_r);
  assign b_last   = pre_r ? !b_desc_r.sil
                          : (!b_desc_r.sil ||
                             sil_idx_r == srsp_pkg::SilIdxW'(srsp_pkg::SilenceLen - 1));
  assign b_done   = b_valid_r && out_ready && b_last;
  assign a_move   = a_valid_r && (!b_valid_r || b_done);
  assign in_ready = !a_valid_r || a_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_desc_r <= in_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      pre_r     <= 1'b0;
      sil_idx_r <= '0;
    end else if (a_move) begin
      b_valid_r <= 1'b1;
      pre_r     <= a_desc_r.wr;
      sil_idx_r <= '0;
    end else if (b_done) begin
      b_valid_r <= 1'b0;
    end else if (b_valid_r && out_ready) begin
      if (pre_r) begin
        pre_r <= 1'b0;
      end else begin
        sil_idx_r <= sil_idx_r + srsp_pkg::SilIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_desc_r <= a_desc_r;
    end
  end

  always_comb begin
    out_valid         = b_valid_r;
    out_write_valid   = 1'b0;
    out_reg_offset    = '0;
    out_reg_value     = '0;
    if (pre_r) begin
      out_write_valid = 1'b1;
      out_reg_offset  = b_desc_r.wr_off;
      out_reg_value   = b_desc_r.wr_val;
    end else if (b_desc_r.sil) begin
      out_write_valid = 1'b1;
      out_reg_offset  = sil_word[15:8];
      out_reg_value   = sil_word[7:0];
    end
    out_fetch_valid   = b_last && b_desc_r.fetch;
    out_fetch_address = (b_last && b_desc_r.fetch) ? b_desc_r.fetch_addr : '0;
    out_playing       = b_desc_r.playing;
    out_headset_on    = b_desc_r.headset;
    out_bad_command   = b_last && b_desc_r.bad;
    out_last          = b_last;
  end

endmodule
`default_nettype wire

FILE: tb/sound_register_stream_player_tb.sv
`default_nettype none
module sound_register_stream_player_tb;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned LongHold = 400;
  localparam logic [2:0] CmdUnusedLo = 3'd6;
  localparam logic [2:0] CmdUnusedHi = 3'd7;

  localparam logic [15:0] SilenceWrites [36] = '{
    16'h6000, 16'h6200, 16'h6308, 16'h6400, 16'h6580, 16'h6800, 16'h6908, 16'h6c00,
    16'h6d80, 16'h9000, 16'h9100, 16'h9200, 16'h9300, 16'h9400, 16'h9500, 16'h9600,
    16'h9700, 16'h9800, 16'h9900, 16'h9a00, 16'h9b00, 16'h9c00, 16'h9d00, 16'h9e00,
    16'h9f00, 16'h7000, 16'h7200, 16'h7300, 16'h7400, 16'h7500, 16'h7800, 16'h7908,
    16'h7c00, 16'h7d80, 16'h8077, 16'h81ff
  };

  typedef struct packed {
    logic        wr;
    logic [7:0]  off;
    logic [7:0]  val;
    logic        fetch;
    logic [31:0] fetch_addr;
    logic        playing;
    logic        headset;
    logic        bad;
    logic        last;
  } play_result_t;

  class player_scoreboard;
    logic [7:0] fade_ticks, wait_code, write_code, end_code;
    srsp_pkg::mode_t mode;
    srsp_pkg::phase_t phase;
    logic [7:0] fade_count, held_addr;
    logic [31:0] song_start, cursor, queued_start, offset_accum;
    logic looping, queued_looping, headset;
    logic [15:0] writes [$];
    play_result_t expected [$];
    int errors, items, results, reg_writes, bad_seen, fades_done;

    function new();
      fade_ticks = srsp_pkg::FadeTicksRst;
      wait_code = srsp_pkg::WaitCodeRst;
      write_code = srsp_pkg::WriteCodeRst;
      end_code = srsp_pkg::EndCodeRst;
      clear_state();
      errors = 0;
      items = 0;
      results = 0;
      reg_writes = 0;
      bad_seen = 0;
      fades_done = 0;
    endfunction

    function void set_reg(srsp_pkg::cfg_idx_t idx, logic [7:0] v);
      case (idx)
        srsp_pkg::CFG_FADE_TICKS: fade_ticks = v;
        srsp_pkg::CFG_WAIT_CODE:  wait_code = v;
        srsp_pkg::CFG_WRITE_CODE: write_code = v;
        srsp_pkg::CFG_END_CODE:   end_code = v;
        default: ;
      endcase
    endfunction

    function void clear_state();
      mode = srsp_pkg::MODE_STOP;
      phase = srsp_pkg::PH_IDLE;
      fade_count = '0;
      held_addr = '0;
      song_start = '0;
      cursor = '0;
      queued_start = '0;
      offset_accum = '0;
      looping = 1'b0;
      queued_looping = 1'b0;
      headset = 1'b0;
    endfunction

    function void do_stop();
      mode = srsp_pkg::MODE_STOP;
      phase = srsp_pkg::PH_IDLE;
      foreach (SilenceWrites[i]) writes.push_back(SilenceWrites[i]);
    endfunction

    function void start_song(logic [31:0] base, logic lp);
      clear_state();
      do_stop();
      song_start = base;
      cursor = base;
      looping = lp;
      mode = srsp_pkg::MODE_PLAY;
    endfunction

    function void tick();
      if (mode == srsp_pkg::MODE_STOP) return;
      if (mode == srsp_pkg::MODE_NEXT || mode == srsp_pkg::MODE_FADE) begin
        if (fade_count >= 5 && fade_count <= 35 && fade_count % 5 == 0)
          writes.push_back({srsp_pkg::RegMaster, 8'((fade_count / 5 - 1) * 8'h11)});
        fade_count = fade_count - 8'd1;
        if (fade_count == 0) begin
          fades_done++;
          if (mode == srsp_pkg::MODE_NEXT) start_song(queued_start, queued_looping);
          else do_stop();
          return;
        end
      end
      if (phase == srsp_pkg::PH_IDLE) phase = srsp_pkg::PH_CMD;
    endfunction

    function bit take_byte(logic [7:0] b);
      logic [7:0] v;
      int k;
      if (phase == srsp_pkg::PH_IDLE || mode == srsp_pkg::MODE_STOP) return 1'b0;
      cursor = cursor + 32'd1;
      case (phase)
        srsp_pkg::PH_CMD: begin
          if (b == wait_code) phase = srsp_pkg::PH_IDLE;
          else if (b == write_code) phase = srsp_pkg::PH_ADDR;
          else if (b == end_code) begin
            if (!looping) do_stop();
            else begin
              offset_accum = '0;
              phase = srsp_pkg::PH_OFF0;
            end
          end else begin
            mode = srsp_pkg::MODE_STOP;
            phase = srsp_pkg::PH_IDLE;
            bad_seen++;
            return 1'b1;
          end
        end
        srsp_pkg::PH_ADDR: begin
          held_addr = b;
          phase = srsp_pkg::PH_DATA;
        end
        srsp_pkg::PH_DATA: begin
          v = b;
          if (headset && held_addr == srsp_pkg::RegWave0 && b == srsp_pkg::Wave0Match)
            v = srsp_pkg::Wave0Subst;
          else if (headset && held_addr == srsp_pkg::RegWave1 && b == srsp_pkg::Wave1Match)
            v = srsp_pkg::Wave1Subst;
          writes.push_back({held_addr, v});
          phase = srsp_pkg::PH_CMD;
        end
        default: begin
          k = int'(phase) - int'(srsp_pkg::PH_OFF0);
          offset_accum = offset_accum | (32'(b) << (8 * k));
          if (phase == srsp_pkg::PH_OFF3) begin
            cursor = song_start + offset_accum;
            phase = srsp_pkg::PH_CMD;
          end else begin
            phase = srsp_pkg::phase_t'(phase + 3'd1);
          end
        end
      endcase
      return 1'b0;
    endfunction

    function void note_input(logic [2:0] cmd, logic [7:0] b, logic [31:0] base, logic le);
      play_result_t r;
      bit bad;
      int n;
      writes.delete();
      bad = 1'b0;
      items++;
      case (cmd)
        srsp_pkg::CMD_TICK: tick();
        srsp_pkg::CMD_BYTE: bad = take_byte(b);
        srsp_pkg::CMD_PLAY: begin
          if (mode == srsp_pkg::MODE_PLAY) begin
            queued_start = base;
            queued_looping = le;
            fade_count = fade_ticks;
            mode = srsp_pkg::MODE_NEXT;
          end else if (mode == srsp_pkg::MODE_NEXT || mode == srsp_pkg::MODE_FADE) begin
            queued_start = base;
            queued_looping = le;
            mode = srsp_pkg::MODE_NEXT;
          end else begin
            start_song(base, le);
          end
        end
        srsp_pkg::CMD_FADE: begin
          fade_count = fade_ticks;
          mode = srsp_pkg::MODE_FADE;
        end
        srsp_pkg::CMD_HEAD: headset = ~headset;
        srsp_pkg::CMD_STOP: do_stop();
        default: ;
      endcase
      n = (writes.size() > 0) ? writes.size() : 1;
      for (int k = 0; k < n; k++) begin
        r.wr = (k < writes.size());
        r.off = r.wr ? writes[k][15:8] : 8'h00;
        r.val = r.wr ? writes[k][7:0] : 8'h00;
        r.last = (k == n - 1);
        r.fetch = r.last && phase != srsp_pkg::PH_IDLE;
        r.fetch_addr = r.fetch ? cursor : 32'h0;
        r.playing = (mode != srsp_pkg::MODE_STOP);
        r.headset = headset;
        r.bad = r.last && bad;
        expected.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(play_result_t got);
      play_result_t want;
      results++;
      if (got.wr) reg_writes++;
      if (expected.size() == 0) begin
        $error("unexpected result: write %0b offset %0h value %0h", got.wr, got.off, got.val);
        errors++;
        return;
      end
      want = expected.pop_front();
      compare_field("write_valid", want.wr, got.wr);
      compare_field("reg_offset", want.off, got.off);
      compare_field("reg_value", want.val, got.val);
      compare_field("fetch_valid", want.fetch, got.fetch);
      compare_field("fetch_address", want.fetch_addr, got.fetch_addr);
      compare_field("playing", want.playing, got.playing);
      compare_field("headset_on", want.headset, got.headset);
      compare_field("bad_command", want.bad, got.bad);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [2:0] in_cmd = '0;
  logic [7:0] in_stream_byte = '0;
  logic [31:0] in_song_base = '0;
  logic in_loop_enable = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  logic in_ready, out_valid;
  logic out_write_valid, out_fetch_valid, out_playing, out_headset_on;
  logic out_bad_command, out_last;
  logic [7:0] out_reg_offset, out_reg_value;
  logic [31:0] out_fetch_address;

  player_scoreboard sb = new();
  int unsigned cycles = 0;
  int sent = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int sink_hold = 0;

  sound_register_stream_player dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_stream_byte(in_stream_byte),
    .in_song_base(in_song_base),
    .in_loop_enable(in_loop_enable),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_write_valid(out_write_valid),
    .out_reg_offset(out_reg_offset),
    .out_reg_value(out_reg_value),
    .out_fetch_valid(out_fetch_valid),
    .out_fetch_address(out_fetch_address),
    .out_playing(out_playing),
    .out_headset_on(out_headset_on),
    .out_bad_command(out_bad_command),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_write_valid, out_reg_offset, out_reg_value, out_fetch_valid,
                       out_fetch_address, out_playing, out_headset_on, out_bad_command,
                       out_last});
  end

  function automatic int idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        sink_hold = LongHold;
      end
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        sink_hold--;
      end else if (calm || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        sink_hold = idle_len() - 1;
      end
    end
  end

  task automatic send(logic [2:0] cmd, logic [7:0] b, logic [31:0] base, logic le);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_stream_byte <= b;
    in_song_base <= base;
    in_loop_enable <= le;
    do @(posedge clk); while (!in_ready);
    sb.note_input(cmd, b, base, le);
    sent++;
  endtask

  task automatic op(logic [2:0] cmd);
    send(cmd, rand_byte(), $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic feed(logic [7:0] b);
    send(srsp_pkg::CMD_BYTE, b, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(srsp_pkg::cfg_idx_t idx, logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic set_regs(logic [7:0] ft, logic [7:0] wc, logic [7:0] wr, logic [7:0] ec);
    write_reg(srsp_pkg::CFG_FADE_TICKS, ft);
    write_reg(srsp_pkg::CFG_WAIT_CODE, wc);
    write_reg(srsp_pkg::CFG_WRITE_CODE, wr);
    write_reg(srsp_pkg::CFG_END_CODE, ec);
    cfg_we <= 1'b0;
  endtask

  task automatic directed();
    feed(8'h00);
    send(srsp_pkg::CMD_PLAY, 8'h00, 32'hffff_fffd, 1'b1);
    op(srsp_pkg::CMD_TICK);
    feed(sb.write_code);
    feed(srsp_pkg::RegWave0);
    op(srsp_pkg::CMD_HEAD);
    feed(srsp_pkg::Wave0Match);
    feed(sb.write_code);
    feed(srsp_pkg::RegWave1);
    feed(srsp_pkg::Wave1Match);
    feed(sb.end_code);
    repeat (4) feed(8'hff);
    op(srsp_pkg::CMD_TICK);
    feed(sb.wait_code);
    op(CmdUnusedLo);
    op(CmdUnusedHi);
    send(srsp_pkg::CMD_PLAY, 8'hff, 32'h0000_0000, 1'b0);
    op(srsp_pkg::CMD_FADE);
    op(srsp_pkg::CMD_STOP);
    op(srsp_pkg::CMD_FADE);
    op(srsp_pkg::CMD_TICK);
    feed(8'hab);
    send(srsp_pkg::CMD_PLAY, 8'h5a, 32'h8000_0000, 1'b0);
    op(srsp_pkg::CMD_TICK);
    feed(sb.end_code);
    // queue a song behind a full fade and run the fade out
    send(srsp_pkg::CMD_PLAY, 8'h00, 32'h0000_1000, 1'b1);
    send(srsp_pkg::CMD_PLAY, 8'h00, 32'h0000_2000, 1'b0);
    repeat (int'(sb.fade_ticks)) op(srsp_pkg::CMD_TICK);
  endtask

  // one tick's worth of well-formed stream: writes, then wait, end or junk
  task automatic phrase();
    int r;
    op(srsp_pkg::CMD_TICK);
    repeat ($urandom_range(0, 3)) begin
      feed(sb.write_code);
      r = $urandom_range(0, 3);
      if (r == 0) begin
        feed(srsp_pkg::RegWave0);
        feed($urandom_range(0, 1) ? srsp_pkg::Wave0Match : rand_byte());
      end else if (r == 1) begin
        feed(srsp_pkg::RegWave1);
        feed($urandom_range(0, 1) ? srsp_pkg::Wave1Match : rand_byte());
      end else begin
        feed(rand_byte());
        feed(rand_byte());
      end
    end
    r = $urandom_range(0, 99);
    if (r < 72) begin
      feed(sb.wait_code);
    end else if (r < 92) begin
      feed(sb.end_code);
      if (sb.looping) repeat (4) feed(rand_byte());
    end else begin
      feed(rand_byte());
    end
  endtask

  task automatic song_traffic(int budget);
    int first, r, n;
    first = sent;
    while (sent - first < budget) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send(srsp_pkg::CMD_PLAY, rand_byte(), $urandom, 1'($urandom_range(0, 1)));
      end else if (r < 10) begin
        op(srsp_pkg::CMD_FADE);
      end else if (r < 15) begin
        op(srsp_pkg::CMD_HEAD);
      end else if (r < 18) begin
        op(srsp_pkg::CMD_STOP);
      end else if (r < 22) begin
        if ($urandom_range(0, 1)) op($urandom_range(0, 1) ? CmdUnusedLo : CmdUnusedHi);
        else feed(rand_byte());
      end else if (r < 32) begin
        n = $urandom_range(1, 3);
        repeat (n) op(srsp_pkg::CMD_TICK);
      end else begin
        phrase();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs(8'd36, 8'h00, 8'h01, 8'h02);
    directed();
    hold_req = 1'b1;
    song_traffic(12);
    drain();

    calm = 1'b1;
    set_regs(8'd255, 8'hff, 8'h00, 8'h80);
    send(srsp_pkg::CMD_PLAY, rand_byte(), $urandom, 1'b1);
    song_traffic(8);
    drain();
    calm = 1'b0;

    set_regs(8'd100, 8'h5a, 8'h5a, 8'h5a);
    song_traffic(6);
    drain();

    set_regs(8'($urandom_range(36, 255)), rand_byte(), rand_byte(), rand_byte());
    send(srsp_pkg::CMD_PLAY, rand_byte(), $urandom, 1'b1);
    song_traffic(8);
    drain();

    $display("covered %0d input transactions giving %0d results, %0d of them register writes",
             sb.items, sb.results, sb.reg_writes);
    $display("%0d fades ran out, %0d unknown command bytes, four register settings",
             sb.fades_done, sb.bad_seen);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
